// ===== rtl/vn3_pkg.sv =====
`default_nettype none
package vn3_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 32;
  localparam int CORNER_FRAC = 30;
  localparam int OUT_FRAC    = 16;
  localparam int OUT_W       = 18;
  localparam int HASH_W      = 31;
  localparam int CORNER_W    = 32;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_AXES    = 3;
  localparam int NUM_STAGES  = 10;
  localparam int IN_TDATA_W  = 3 * COORD_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam logic [31:0] HASH_MUL_Z = 32'd131;
  localparam int          HASH_SHIFT = 13;

  localparam logic [HASH_W-1:0] HASH_C1 = HASH_W'(15731);
  localparam logic [HASH_W-1:0] HASH_C2 = HASH_W'(789221);
  localparam logic [HASH_W-1:0] HASH_C3 = HASH_W'(1376312589);

  typedef logic [FRAC_BITS-1:0]       frac_t;
  typedef logic [HASH_W-1:0]          hash_t;
  typedef logic signed [CORNER_W-1:0] corner_t;

  typedef struct packed {
    logic en_sq;
    logic en_lin;
    logic en_fin;
  } hash_ctl_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lerp_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/value_noise_3d_trilinear.sv =====
// 3D value noise, trilinear blend of hashed lattice corners.
// Input channel s_axis: one beat carries a point (x, y, z), each signed
// fixed point with 16 fraction bits. Output channel m_axis: one beat per
// input beat, in order, carrying the noise value (signed, 16 fraction bits,
// 65536 = 1.0).
// Throughput: one beat per cycle while m_axis is not stalled; every stage of
// the ten-stage pipeline takes a new beat each cycle when it can move (a floor
// and hash seed stage, three hash multiplier stages the last of which forms
// the corner values, then a multiply and an add stage for each of the x, y and
// z blends).
// Each stage holds a valid bit; a stage loads when it is empty or when the
// stage after it moves, so bubbles are squeezed out and s_axis_tready stays
// high while any stage has room. When m_axis_tready is low the last stage
// holds its beat and the pipeline fills up behind it; nothing is lost or
// repeated.
// Reset clears all valid bits; no output beat is presented until new input.
`default_nettype none
module value_noise_3d_trilinear
  import vn3_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire  [IN_TDATA_W-1:0]   s_axis_tdata,   // coord_x, coord_y, coord_z
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata    // noise_value, zero pad
);

  logic [NUM_STAGES-1:0] vld_q, vld_d, en;

  logic [COORD_W-1:0]   coord  [NUM_AXES];
  logic [31:0]          lat    [NUM_AXES];
  logic [31:0]          base;
  logic [31:0]          nc     [NUM_CORNERS];
  logic [31:0]          nx     [NUM_CORNERS];
  hash_t                n_d    [NUM_CORNERS];
  hash_t                n_q    [NUM_CORNERS];
  logic [2*FRAC_BITS-1:0] ff   [NUM_AXES];
  frac_t                f_q    [NUM_AXES];
  frac_t                sq_q   [NUM_AXES];
  logic [FRAC_BITS+1:0] qf     [NUM_AXES];
  logic [2*FRAC_BITS+1:0] wp   [NUM_AXES];
  frac_t                wt_q   [1:NUM_STAGES-3][NUM_AXES];
  corner_t              corner [NUM_CORNERS];
  corner_t              ax     [4];
  corner_t              by     [2];
  corner_t              rz;
  hash_ctl_t            hash_ctl;

  // handshake: a stage loads when empty or when its successor moves
  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];

  // stage 0: cell floor, corner hash seeds, fraction squares
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      coord[a] = s_axis_tdata[a*COORD_W +: COORD_W];
      lat[a]   = {{FRAC_BITS{coord[a][COORD_W-1]}}, coord[a][COORD_W-1:FRAC_BITS]};
      ff[a]    = coord[a][FRAC_BITS-1:0] * coord[a][FRAC_BITS-1:0];
    end
    base = lat[0] + lat[1] * HASH_MUL_Y + lat[2] * HASH_MUL_Z;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      nc[k] = base + (k[0] ? 32'd1 : 32'd0) + (k[1] ? HASH_MUL_Y : 32'd0)
                   + (k[2] ? HASH_MUL_Z : 32'd0);
      nx[k] = (nc[k] << HASH_SHIFT) ^ nc[k];
      n_d[k] = nx[k][HASH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        n_q[k] <= n_d[k];
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        f_q[a]  <= coord[a][FRAC_BITS-1:0];
        sq_q[a] <= ff[a][2*FRAC_BITS-1:FRAC_BITS];
      end
    end
  end

  // stage 1: smoothstep weights, carried along to the blends
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      qf[a] = (FRAC_BITS+2)'(3) << FRAC_BITS;
      qf[a] = qf[a] - {1'b0, f_q[a], 1'b0};
      wp[a] = sq_q[a] * qf[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        wt_q[1][a] <= wp[a][2*FRAC_BITS-1:FRAC_BITS];
      end
    end
    for (int s = 2; s <= NUM_STAGES - 3; s++) begin
      if (en[s]) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          wt_q[s][a] <= wt_q[s-1][a];
        end
      end
    end
  end

  // stages 1..3: corner hashes
  assign hash_ctl = '{en_sq: en[1], en_lin: en[2], en_fin: en[3]};

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    vn3_hash u_hash (
      .clk_i    (clk_i),
      .ctl_i    (hash_ctl),
      .n_i      (n_q[k]),
      .corner_o (corner[k])
    );
  end

  // stages 4..5: blend along x
  for (genvar j = 0; j < 4; j++) begin : g_lerp_x
    vn3_lerp u_lerp (
      .clk_i (clk_i),
      .ctl_i ('{en_mul: en[4], en_sum: en[5]}),
      .a_i   (corner[2*j]),
      .b_i   (corner[2*j+1]),
      .w_i   (wt_q[3][0]),
      .y_o   (ax[j])
    );
  end

  // stages 6..7: blend along y
  for (genvar j = 0; j < 2; j++) begin : g_lerp_y
    vn3_lerp u_lerp (
      .clk_i (clk_i),
      .ctl_i ('{en_mul: en[6], en_sum: en[7]}),
      .a_i   (ax[2*j]),
      .b_i   (ax[2*j+1]),
      .w_i   (wt_q[5][1]),
      .y_o   (by[j])
    );
  end

  // stages 8..9: blend along z, stage 9 is the output register
  vn3_lerp u_lerp_z (
    .clk_i (clk_i),
    .ctl_i ('{en_mul: en[8], en_sum: en[9]}),
    .a_i   (by[0]),
    .b_i   (by[1]),
    .w_i   (wt_q[7][2]),
    .y_o   (rz)
  );

  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}},
                          rz[CORNER_FRAC-OUT_FRAC+OUT_W-1:CORNER_FRAC-OUT_FRAC]};

endmodule
`default_nettype wire

// ===== rtl/vn3_hash.sv =====
`default_nettype none
module vn3_hash
  import vn3_pkg::*;
(
  input  wire       clk_i,
  input  hash_ctl_t ctl_i,
  input  hash_t     n_i,
  output corner_t   corner_o
);

  hash_t   n1_q, nn_q, n2_q, t_q;
  hash_t   m;
  corner_t corner_q;

  // n*n
  always_ff @(posedge clk_i) begin
    if (ctl_i.en_sq) begin
      n1_q <= n_i;
      nn_q <= n_i * n_i;
    end
  end

  // n*n*15731 + 789221
  always_ff @(posedge clk_i) begin
    if (ctl_i.en_lin) begin
      n2_q <= n1_q;
      t_q  <= nn_q * HASH_C1 + HASH_C2;
    end
  end

  assign m = n2_q * t_q + HASH_C3;

  // corner = 1.0 - m / 2^30
  always_ff @(posedge clk_i) begin
    if (ctl_i.en_fin) begin
      corner_q <= corner_t'(64'sd1 <<< CORNER_FRAC) - $signed({1'b0, m});
    end
  end

  assign corner_o = corner_q;

endmodule
`default_nettype wire

// ===== rtl/vn3_lerp.sv =====
`default_nettype none
module vn3_lerp
  import vn3_pkg::*;
(
  input  wire       clk_i,
  input  lerp_ctl_t ctl_i,
  input  corner_t   a_i,
  input  corner_t   b_i,
  input  frac_t     w_i,
  output corner_t   y_o
);

  localparam int PROD_W = CORNER_W + 1 + FRAC_BITS + 1;

  logic signed [CORNER_W:0]   diff;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PROD_W-1:0]   sum;
  corner_t                    a_q, y_q;

  // a + floor((b-a)*w / 2^F) equals floor((a*(1-w) + b*w) / 2^F)
  assign diff   = $signed({b_i[CORNER_W-1], b_i}) - $signed({a_i[CORNER_W-1], a_i});
  assign prod_d = PROD_W'(diff) * PROD_W'($signed({1'b0, w_i}));

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_mul) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  assign sum = PROD_W'(a_q) + (prod_q >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_sum) begin
      y_q <= sum[CORNER_W-1:0];
    end
  end

  assign y_o = y_q;

endmodule
`default_nettype wire
